// File: rtl/dot_stuffed_text_decoder_unit_assert.svh
// Assertion macros for the dot-stuffed text decoder.
// Included by the checker; expects clk_i and rst_ni in scope.
`ifndef DOT_STUFFED_TEXT_DECODER_UNIT_ASSERT_SVH
`define DOT_STUFFED_TEXT_DECODER_UNIT_ASSERT_SVH

// clocked check, off while reset is asserted
`define DSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// clocked check that also holds during reset
`define DSD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: rtl/dsd_pkg.sv
// Shared types and character codes for the dot-stuffed text decoder.
// No dependencies.
package dsd_pkg;

  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;

  // group of decoded bytes produced by one input byte
  typedef struct packed {
    logic [1:0]       cnt;
    logic [2:0][7:0]  bytes;   // bytes[0] goes out first
    logic             end_seen;
    logic             warn;
    logic             aborted;
  } grp_t;

endpackage

// File: rtl/dot_stuffed_text_decoder_unit.sv
// Top level of the dot-stuffed text decoder: input register, parser and
// result register. Depends on dsd_pkg, dsd_parser and dsd_out_buf.

// Decodes a dot-stuffed, CRLF text body one byte per transfer. Each input
// byte yields zero to three output bytes; a byte that yields at most one
// output sustains one byte per cycle while out_ready_i is high, passing the
// input register and then the result register. Bytes that expand to two
// or three outputs hold the input until the result register has sent all
// but their last byte. last_in_run_o marks each group's final byte. The
// user must write strict_mode via cfg_we_i only while idle; not enforced.
module dot_stuffed_text_decoder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_strict_mode_i,
  input  logic       data_valid_i,
  output logic       data_ready_o,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_in_run_o,
  output logic       end_seen_o,
  output logic       format_warning_o,
  output logic       aborted_o
);

  logic          in_vld_q;
  logic [7:0]    in_byte_q;
  logic          can_load;
  logic          advance;
  dsd_pkg::grp_t grp;

  assign advance      = in_vld_q && can_load;
  assign data_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (data_ready_o) begin
      in_vld_q <= data_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (data_ready_o && data_valid_i) begin
      in_byte_q <= data_byte_i;
    end
  end

  dsd_parser u_parser (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_strict_mode_i (cfg_strict_mode_i),
    .step_i            (advance),
    .byte_i            (in_byte_q),
    .grp_o             (grp)
  );

  dsd_out_buf u_out_buf (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .load_i           (advance),
    .grp_i            (grp),
    .can_load_o       (can_load),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_byte_o       (out_byte_o),
    .last_in_run_o    (last_in_run_o),
    .end_seen_o       (end_seen_o),
    .format_warning_o (format_warning_o),
    .aborted_o        (aborted_o)
  );

endmodule

// File: rtl/dsd_parser.sv
// Line parser: state, sticky warning and mode register, plus the
// per-byte decode into a group of up to three output bytes. Uses dsd_pkg.
module dsd_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_strict_mode_i,
  input  logic          step_i,
  input  logic [7:0]    byte_i,
  output dsd_pkg::grp_t grp_o
);

  localparam logic [2:0] StBol    = 3'd0;
  localparam logic [2:0] StBegDot = 3'd1;
  localparam logic [2:0] StMid    = 3'd2;
  localparam logic [2:0] StDotCr  = 3'd3;
  localparam logic [2:0] StCr     = 3'd4;
  localparam logic [2:0] StEnd    = 3'd5;
  localparam logic [2:0] StAbort  = 3'd6;

  logic [2:0] state_q, state_d;
  logic       warn_q, warn_d;
  logic       strict_q;

  // line-start handling of one byte
  logic [2:0] ls_state;
  logic       ls_has;
  logic       ls_warn;

  always_comb begin
    ls_has  = 1'b0;
    ls_warn = 1'b0;
    if (byte_i == dsd_pkg::CH_DOT) begin
      ls_state = StBegDot;
    end else if (byte_i == dsd_pkg::CH_CR) begin
      ls_state = StCr;
    end else if (byte_i == dsd_pkg::CH_LF) begin
      ls_state = StBol;
      ls_has   = 1'b1;
      ls_warn  = 1'b1;
    end else begin
      ls_state = StMid;
      ls_has   = 1'b1;
    end
  end

  logic [1:0]      cnt;
  logic [2:0][7:0] bytes;

  always_comb begin
    state_d = state_q;
    warn_d  = warn_q;
    cnt     = 2'd0;
    bytes   = '0;
    case (state_q)
      StBegDot: begin
        if (byte_i == dsd_pkg::CH_DOT) begin
          cnt      = 2'd1;
          bytes[0] = dsd_pkg::CH_DOT;
          state_d  = StMid;
        end else if (byte_i == dsd_pkg::CH_CR) begin
          state_d = StDotCr;
        end else if (byte_i == dsd_pkg::CH_LF) begin
          warn_d  = 1'b1;
          state_d = StEnd;
        end else begin
          warn_d   = 1'b1;
          cnt      = 2'd2;
          bytes[0] = dsd_pkg::CH_DOT;
          bytes[1] = byte_i;
          state_d  = StMid;
        end
      end
      StMid: begin
        if (byte_i == dsd_pkg::CH_CR) begin
          state_d = StCr;
        end else if (byte_i == dsd_pkg::CH_LF) begin
          warn_d   = 1'b1;
          cnt      = 2'd1;
          bytes[0] = dsd_pkg::CH_LF;
          state_d  = StBol;
        end else begin
          cnt      = 2'd1;
          bytes[0] = byte_i;
        end
      end
      StDotCr, StEnd: begin
        if (state_q == StDotCr && byte_i == dsd_pkg::CH_LF) begin
          state_d = StEnd;
        end else if (strict_q) begin
          // strict: bad dot-CR aborts; text after terminator is dropped
          if (state_q == StDotCr) begin
            state_d = StAbort;
          end else begin
            warn_d = 1'b1;
          end
        end else begin
          // write the terminator back out as a text line
          warn_d   = 1'b1;
          cnt      = ls_has ? 2'd3 : 2'd2;
          bytes[0] = dsd_pkg::CH_DOT;
          bytes[1] = dsd_pkg::CH_LF;
          bytes[2] = byte_i;
          state_d  = ls_state;
        end
      end
      StCr: begin
        if (byte_i == dsd_pkg::CH_LF) begin
          cnt      = 2'd1;
          bytes[0] = dsd_pkg::CH_LF;
          state_d  = StBol;
        end else if (strict_q) begin
          state_d = StAbort;
        end else begin
          warn_d   = 1'b1;
          cnt      = ls_has ? 2'd2 : 2'd1;
          bytes[0] = dsd_pkg::CH_LF;
          bytes[1] = byte_i;
          state_d  = ls_state;
        end
      end
      StAbort: begin
        state_d = StAbort;
      end
      default: begin
        cnt      = {1'b0, ls_has};
        bytes[0] = byte_i;
        state_d  = ls_state;
        warn_d   = warn_q | ls_warn;
      end
    endcase
  end

  assign grp_o.cnt      = cnt;
  assign grp_o.bytes    = bytes;
  assign grp_o.end_seen = (state_d == StEnd);
  assign grp_o.warn     = warn_d;
  assign grp_o.aborted  = (state_d == StAbort);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StBol;
      warn_q   <= 1'b0;
      strict_q <= 1'b0;
    end else begin
      if (step_i) begin
        state_q <= state_d;
        warn_q  <= warn_d;
      end
      if (cfg_we_i) begin
        strict_q <= cfg_strict_mode_i;
      end
    end
  end

endmodule

// File: rtl/dsd_out_buf.sv
// Result register: holds one decoded group and sends it one byte per
// transfer, shifting the remaining bytes down. Uses dsd_pkg.
module dsd_out_buf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  dsd_pkg::grp_t grp_i,
  output logic          can_load_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_byte_o,
  output logic          last_in_run_o,
  output logic          end_seen_o,
  output logic          format_warning_o,
  output logic          aborted_o
);

  logic [1:0]      cnt_q;
  logic [2:0][7:0] bytes_q;
  logic            end_q, warn_q, abort_q;
  logic            pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o && out_ready_i;
  // free now, or the last byte leaves this cycle
  assign can_load_o  = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (load_i) begin
      cnt_q <= grp_i.cnt;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bytes_q <= grp_i.bytes;
      end_q   <= grp_i.end_seen;
      warn_q  <= grp_i.warn;
      abort_q <= grp_i.aborted;
    end else if (pop) begin
      bytes_q[0] <= bytes_q[1];
      bytes_q[1] <= bytes_q[2];
    end
  end

  assign out_byte_o       = bytes_q[0];
  assign last_in_run_o    = (cnt_q == 2'd1);
  assign end_seen_o       = end_q;
  assign format_warning_o = warn_q;
  assign aborted_o        = abort_q;

endmodule

// File: rtl/dsd_checker.sv
// Port-level checks for the dot-stuffed text decoder, bound to the top.
// Uses the macros in dot_stuffed_text_decoder_unit_assert.svh.
`include "dot_stuffed_text_decoder_unit_assert.svh"

module dsd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       last_in_run_o,
  input logic       end_seen_o,
  input logic       format_warning_o,
  input logic       aborted_o
);

  // remembers that some earlier result carried the warning
  logic seen_warn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_warn_q <= 1'b0;
    end else if (out_valid_o && format_warning_o) begin
      seen_warn_q <= 1'b1;
    end
  end

  // the aborted state and the terminator state never emit bytes
  `DSD_ASSERT(a_no_abort_out, out_valid_o |-> !aborted_o, "result while aborted")
  `DSD_ASSERT(a_no_end_out, out_valid_o |-> !end_seen_o, "result in terminator state")
  `DSD_ASSERT(a_warn_sticky, (out_valid_o && seen_warn_q) |-> format_warning_o,
              "warning flag dropped")
  `DSD_ASSERT(a_out_hold, (out_valid_o && !out_ready_i) |=>
              (out_valid_o && $stable(out_byte_o) && $stable(last_in_run_o)),
              "stalled result changed")

endmodule

bind dot_stuffed_text_decoder_unit dsd_checker u_dsd_checker (.*);
